/* design/sehsl_pkg.sv */
// shared constants and types for the snow effect pixel pipeline
`timescale 1ns / 1ps

package sehsl_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // divisor width: largest divisor is six times an 8-bit delta
    localparam int DW = 11;
    localparam int LANES = 3;

    localparam int LANE_L = 0;
    localparam int LANE_S = 1;
    localparam int LANE_H = 2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNOW_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_BOOST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED     = 3'd4;

    localparam logic [15:0] GAIN_RESET = 16'd4096;
    localparam logic [15:0] SNOW_RESET = 16'd32768;

    typedef struct packed {
        logic [15:0] gain;
        logic [15:0] snow_level;
        logic        dark_boost;
        logic        gray;
        logic        sgn;
    } sehsl_cfg_t;

endpackage

/* design/sehsl_pre.sv */
// input stage: sign flip, min/max, lightness by reciprocal, divider setup for s and h
`timescale 1ns / 1ps

module sehsl_pre
    import sehsl_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF,
    localparam int NW = F + 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [7:0]       red_in,
    input  logic [7:0]       green_in,
    input  logic [7:0]       blue_in,
    input  sehsl_cfg_t       cfg,
    output logic             out_valid,
    output logic             out_gray,
    output logic [NW-1:0]    num [LANES],
    output logic [DW-1:0]    den [LANES]
);

    // lightness numerator is below 2^(F+8); divide by 255 with a reciprocal
    localparam int XW = F + 8;
    localparam int MW = F + 9;
    localparam int SH = F + 16;
    localparam logic [63:0]   RECIP   = ((64'd1 << SH) + 64'd254) / 64'd255;
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

    logic              valid_reg;
    logic              gray_reg;
    logic [NW-1:0]     num_reg [LANES];
    logic [DW-1:0]     den_reg [LANES];
    logic [NW-1:0]     num_next [LANES];
    logic [DW-1:0]     den_next [LANES];

    logic [7:0]        flip;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [7:0]        mx;
    logic [7:0]        mn;
    logic [7:0]        dl;
    logic [8:0]        sum;
    logic [8:0]        den_s;
    logic [DW-1:0]     d6;
    logic signed [11:0] dd;
    logic signed [11:0] n;
    logic [11:0]       nh;
    logic [XW-1:0]     lx;
    logic [XW+MW-1:0]  lprod;

    always_comb
    begin
        flip = {cfg.sgn, 7'b0};
        r = red_in ^ flip;
        g = green_in ^ flip;
        b = blue_in ^ flip;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        dl = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        den_s = (sum <= 9'd255) ? sum : (9'd510 - sum);
        d6 = DW'(dl) * DW'(6);
        dd = $signed({4'b0, dl});
        if (mx == r)
        begin
            n = $signed({4'b0, g}) - $signed({4'b0, b});
        end
        else if (mx == g)
        begin
            n = (dd <<< 1) + $signed({4'b0, b}) - $signed({4'b0, r});
        end
        else
        begin
            n = (dd <<< 2) + $signed({4'b0, r}) - $signed({4'b0, g});
        end
        // wrap negative hue into one turn
        if (n < 0)
        begin
            n = n + $signed({1'b0, d6});
        end
        nh = n;

        // sum/510 rounded equals (sum*one/2 + 127)/255 floored
        if (cfg.gray)
        begin
            lx = (XW'(r) << F) + XW'(127);
        end
        else
        begin
            lx = (XW'(sum) << (F - 1)) + XW'(127);
        end
        lprod = (XW+MW)'(lx) * (XW+MW)'(RECIP_M);
        num_next[LANE_L] = NW'(lprod >> SH);
        den_next[LANE_L] = DW'(1);

        // rounding: add half the divisor before the divide
        num_next[LANE_S] = (NW'(dl) << F) + NW'(den_s >> 1);
        den_next[LANE_S] = DW'(den_s);
        num_next[LANE_H] = (NW'(nh) << F) + NW'(d6 >> 1);
        den_next[LANE_H] = d6;
        if (cfg.gray || (dl == 8'd0))
        begin
            num_next[LANE_S] = '0;
            den_next[LANE_S] = DW'(1);
            num_next[LANE_H] = '0;
            den_next[LANE_H] = DW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gray_reg <= cfg.gray;
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[l] <= num_next[l];
                den_reg[l] <= den_next[l];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_gray  = gray_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

/* design/sehsl_div.sv */
// pipelined restoring divider for saturation and hue, lightness rides alongside
`timescale 1ns / 1ps

module sehsl_div
    import sehsl_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF,
    localparam int NW = F + 11,
    localparam int Q = F + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic          in_gray,
    input  logic [NW-1:0] num [LANES],
    input  logic [DW-1:0] den [LANES],
    output logic          out_valid,
    output logic          out_gray,
    output logic [Q-1:0]  quo [LANES]
);

    localparam int RW = DW;

    logic          valid_reg [Q];
    logic          gray_reg  [Q];
    logic [RW-1:0] rem_reg   [Q][LANES];
    logic [Q-1:0]  low_reg   [Q][LANES];
    logic [DW-1:0] den_reg   [Q][LANES];

    for (genvar s = 0; s < Q; s++)
    begin : g_stage
        logic          v_i;
        logic          g_i;
        logic [RW-1:0] rem_i  [LANES];
        logic [Q-1:0]  low_i  [LANES];
        logic [DW-1:0] den_i  [LANES];
        logic [RW-1:0] rem_next [LANES];
        logic [Q-1:0]  low_next [LANES];

        if (s == 0)
        begin : g_first
            // upper numerator bits are always below the divisor
            always_comb
            begin
                v_i = in_valid;
                g_i = in_gray;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_i[l] = RW'(num[l][NW-1:Q]);
                    low_i[l] = num[l][Q-1:0];
                    den_i[l] = den[l];
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_i = valid_reg[s-1];
                g_i = gray_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_i[l] = rem_reg[s-1][l];
                    low_i[l] = low_reg[s-1][l];
                    den_i[l] = den_reg[s-1][l];
                end
            end
        end

        always_comb
        begin
            logic [RW:0] trial;
            logic        ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_i[l], low_i[l][Q-1]};
                ge = (trial >= {1'b0, den_i[l]});
                rem_next[l] = ge ? RW'(trial - {1'b0, den_i[l]}) : RW'(trial);
                low_next[l] = {low_i[l][Q-2:0], ge};
                // lightness is already a quotient, just carry it
                if (l == LANE_L)
                begin
                    rem_next[l] = '0;
                    low_next[l] = low_i[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                gray_reg[s] <= g_i;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[l];
                    low_reg[s][l] <= low_next[l];
                    den_reg[s][l] <= den_i[l];
                end
            end
        end
    end

    assign out_valid = valid_reg[Q-1];
    assign out_gray  = gray_reg[Q-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = low_reg[Q-1][l];
        end
    end

endmodule

/* design/sehsl_light.sv */
// lightness adjust: optional dark boost, then snow gain outside the blue band
`timescale 1ns / 1ps

module sehsl_light
    import sehsl_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF,
    localparam int LW = F + 1,
    localparam int OW = F + 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic          in_gray,
    input  logic [LW-1:0] l_in,
    input  logic [LW-1:0] s_in,
    input  logic [LW-1:0] h_in,
    input  sehsl_cfg_t    cfg,
    output logic          out_valid,
    output logic          out_gray,
    output logic [OW-1:0] l_out,
    output logic [LW-1:0] s_out,
    output logic [LW-1:0] h_out
);

    localparam int NST = 6;
    localparam int MW1 = F + 10;
    localparam int XW = 2 * F + 11;
    localparam int ZW = F + 6;
    localparam int K = ZW + 5;
    localparam int MW = ZW + 1;
    localparam int PW = LW + 16;
    localparam int CW = F + 17;

    localparam longint ONE = longint'(1) << F;
    localparam longint THR = ((longint'(100) << F) + 127) / 255;
    localparam longint H_LO = ((longint'(514) << F) + 500) / 1000;
    localparam longint H_HI = ((longint'(630) << F) + 500) / 1000;
    localparam longint S_MIN = ((longint'(196) << F) + 500) / 1000;
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'd24) / 64'd25;

    localparam logic [LW-1:0]  THR_L   = LW'(THR);
    localparam logic [LW-1:0]  H_LO_L  = LW'(H_LO);
    localparam logic [LW-1:0]  H_HI_L  = LW'(H_HI);
    localparam logic [LW-1:0]  S_MIN_L = LW'(S_MIN);
    localparam logic [MW1-1:0] C500    = MW1'(500) << F;
    localparam logic [XW-1:0]  HALF_D  = XW'(100) << F;
    localparam logic [MW-1:0]  RECIP_M = MW'(RECIP);

    logic          valid_reg [NST];
    logic          gray_reg  [NST];
    logic [LW-1:0] s_reg     [NST];
    logic [LW-1:0] h_reg     [NST];
    logic [LW-1:0] l_reg     [4];
    logic          boost_reg [3];

    logic [MW1-1:0] m1_reg;
    logic [XW-1:0]  x_reg;
    logic [ZW-1:0]  z_reg;
    logic [LW-1:0]  l1_reg;
    logic [PW-1:0]  p_reg;
    logic           mul_reg;
    logic [OW-1:0]  ladj_reg;

    logic [MW1-1:0]  m1_next;
    logic            boost_next;
    logic [XW-1:0]   x_next;
    logic [ZW-1:0]   z_next;
    logic [ZW+MW-1:0] qprod;
    logic [LW-1:0]   l1_next;
    logic            snow_hit;
    logic            band;
    logic [PW-1:0]   p_next;
    logic [OW-1:0]   ladj_next;

    always_comb
    begin
        // stage a: 500*one - 765*l, boost select
        m1_next = C500 - (MW1'(l_in) * MW1'(765));
        boost_next = cfg.dark_boost && (l_in <= THR_L);
        // stage b
        x_next = XW'(l_reg[0]) * XW'(m1_reg);
        // stage c: divide by 200*one as shift then divide by 25
        z_next = ZW'((x_reg + HALF_D) >> (F + 3));
        // stage d
        qprod = (ZW+MW)'(z_reg) * (ZW+MW)'(RECIP_M);
        l1_next = boost_reg[2] ? LW'(qprod >> K) : l_reg[2];
        // stage e
        snow_hit = ((CW'(l1_reg) << 16) <= (CW'(cfg.snow_level) << F));
        band = !gray_reg[3] && (h_reg[3] >= H_LO_L) && (h_reg[3] <= H_HI_L)
            && (s_reg[3] >= S_MIN_L) && (l1_reg >= S_MIN_L);
        p_next = PW'(l1_reg) * PW'(cfg.gain);
        // stage f
        ladj_next = mul_reg ? OW'((p_reg + PW'(2048)) >> 12) : OW'(l_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gray_reg[0] <= in_gray;
            s_reg[0] <= s_in;
            h_reg[0] <= h_in;
            for (int i = 1; i < NST; i++)
            begin
                gray_reg[i] <= gray_reg[i-1];
                s_reg[i] <= s_reg[i-1];
                h_reg[i] <= h_reg[i-1];
            end
            l_reg[0] <= l_in;
            l_reg[1] <= l_reg[0];
            l_reg[2] <= l_reg[1];
            l_reg[3] <= l1_reg;
            boost_reg[0] <= boost_next;
            boost_reg[1] <= boost_reg[0];
            boost_reg[2] <= boost_reg[1];
            m1_reg <= m1_next;
            x_reg <= x_next;
            z_reg <= z_next;
            l1_reg <= l1_next;
            p_reg <= p_next;
            mul_reg <= snow_hit && !band;
            ladj_reg <= ladj_next;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_gray  = gray_reg[NST-1];
    assign l_out = ladj_reg;
    assign s_out = s_reg[NST-1];
    assign h_out = h_reg[NST-1];

endmodule

/* design/sehsl_rgb.sv */
// hsl back to rgb, scale to bytes, clamp and output register
`timescale 1ns / 1ps

module sehsl_rgb
    import sehsl_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF,
    localparam int LW = F + 1,
    localparam int OW = F + 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic          in_gray,
    input  logic [OW-1:0] l_in,
    input  logic [LW-1:0] s_in,
    input  logic [LW-1:0] h_in,
    input  logic          sgn,
    output logic          out_valid,
    output logic [7:0]    red_out,
    output logic [7:0]    green_out,
    output logic [7:0]    blue_out
);

    localparam int NST = 6;
    localparam int TW = F + 3;
    localparam int SPW = 2 * LW;
    localparam int CTW = F + 2;
    localparam int AW = F + 6;
    localparam int PW = AW + CTW + 1;
    localparam int CW = F + 8;
    localparam int VW = F + 17;

    localparam logic [TW-1:0]  ONE_T  = TW'(1) << F;
    localparam logic [LW-1:0]  ONE_L  = LW'(1) << F;
    localparam logic [SPW:0]   HALF_S = (SPW+1)'(1) << (F - 1);
    localparam logic [PW-1:0]  HALF_P = PW'(1) << (F - 1);
    localparam logic [VW-1:0]  HALF_V = VW'(1) << (F - 1);

    logic            valid_reg [NST];
    logic            gray_reg  [NST];
    logic [OW-1:0]   l_reg     [5];
    logic [LW-1:0]   s_reg     [3];
    logic            hi_reg    [3];

    logic [LW-1:0]   t_reg  [LANES];
    logic [SPW-1:0]  st_reg [LANES];
    logic [CTW-1:0]  ct_reg [LANES];
    logic signed [AW-1:0] a_reg;
    logic signed [PW-1:0] p_reg [LANES];
    logic signed [CW-1:0] c_reg [LANES];
    logic [7:0]      byte_reg [LANES];

    logic [TW-1:0]   h6;
    logic [TW-1:0]   tw [LANES];
    logic [LW-1:0]   t_next [LANES];
    logic [SPW-1:0]  st_next [LANES];
    logic [CTW-1:0]  ct_next [LANES];
    logic            hi_next;
    logic signed [AW-1:0] a_next;
    logic signed [PW-1:0] p_next [LANES];
    logic signed [CW-1:0] c_next [LANES];
    logic [7:0]      byte_next [LANES];

    always_comb
    begin
        // stage 1: sector of the hue and the three ramps
        h6 = TW'(h_in) * TW'(6);
        if (h6 < (ONE_T << 1))
        begin
            tw[0] = (ONE_T << 1) - h6;
            tw[1] = h6;
            tw[2] = '0;
        end
        else if (h6 < (ONE_T << 2))
        begin
            tw[0] = '0;
            tw[1] = (ONE_T << 2) - h6;
            tw[2] = h6 - (ONE_T << 1);
        end
        else
        begin
            tw[0] = h6 - (ONE_T << 2);
            tw[1] = '0;
            tw[2] = (ONE_T * TW'(6)) - h6;
        end
        for (int i = 0; i < LANES; i++)
        begin
            t_next[i] = (tw[i] > ONE_T) ? ONE_L : LW'(tw[i]);
        end
    end

    always_comb
    begin
        logic [SPW:0]     rs;
        logic [PW-1:0]    mag;
        logic [PW-1:0]    rmag;
        logic signed [CW-1:0] base;
        logic [VW-1:0]    w;
        hi_next = ((AW'(l_reg[1]) << 1) >= AW'(ONE_L));
        a_next = hi_next ? ($signed(AW'(ONE_L)) - $signed(AW'(l_reg[1])))
                         : $signed(AW'(l_reg[1]));
        base = hi_reg[1] ? ($signed(CW'(l_reg[3]) << 1) - $signed(CW'(ONE_L)))
                         : '0;
        for (int i = 0; i < LANES; i++)
        begin
            // stage 2
            st_next[i] = SPW'(s_reg[0]) * SPW'(t_reg[i]);
            // stage 3: ct = round(2*s*t) + one - s
            rs = ((SPW+1)'(st_reg[i]) << 1) + HALF_S;
            ct_next[i] = CTW'(rs >> F) + CTW'(ONE_L) - CTW'(s_reg[1]);
            // stage 4
            p_next[i] = PW'(a_reg) * $signed({1'b0, ct_reg[i]});
            // stage 5: round half away from zero, then add 2l - one on the upper half
            mag = p_reg[i][PW-1] ? PW'(-p_reg[i]) : PW'(p_reg[i]);
            rmag = (mag + HALF_P) >> F;
            c_next[i] = (p_reg[i][PW-1] ? -$signed(CW'(rmag)) : $signed(CW'(rmag))) + base;
            // stage 6: scale to a byte and clamp
            w = ((VW'(c_reg[i]) * VW'(255)) + HALF_V) >> F;
            if (c_reg[i][CW-1])
            begin
                byte_next[i] = 8'd0;
            end
            else if (w > VW'(255))
            begin
                byte_next[i] = 8'd255;
            end
            else
            begin
                byte_next[i] = w[7:0];
            end
            byte_next[i] = byte_next[i] ^ {sgn, 7'b0};
        end
        if (gray_reg[4])
        begin
            byte_next[1] = 8'd0;
            byte_next[2] = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gray_reg[0] <= in_gray;
            for (int i = 1; i < NST; i++)
            begin
                gray_reg[i] <= gray_reg[i-1];
            end
            l_reg[0] <= l_in;
            for (int i = 1; i < 5; i++)
            begin
                l_reg[i] <= l_reg[i-1];
            end
            s_reg[0] <= s_in;
            s_reg[1] <= s_reg[0];
            s_reg[2] <= s_reg[1];
            hi_reg[0] <= hi_next;
            hi_reg[1] <= hi_reg[0];
            hi_reg[2] <= hi_reg[1];
            a_reg <= a_next;
            for (int i = 0; i < LANES; i++)
            begin
                t_reg[i] <= t_next[i];
                st_reg[i] <= st_next[i];
                ct_reg[i] <= ct_next[i];
                p_reg[i] <= p_next[i];
                c_reg[i] <= c_next[i];
                byte_reg[i] <= byte_next[i];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign red_out   = byte_reg[0];
    assign green_out = byte_reg[1];
    assign blue_out  = byte_reg[2];

endmodule

/* design/snow_effect_hsl_pixel_top.sv */
// top level of the snow effect pixel pipeline with configuration registers
//
// channel   valid      stall      payload
// pixel     pix_valid  pix_stall  red_in, green_in, blue_in
// result    res_valid  res_stall  red_out, green_out, blue_out
//
// one pixel per cycle while the pipe is not held; the divider retires one quotient bit per stage,
// and the boost, gain and rgb stages follow it
// all stages advance together; res_stall on a valid result holds the whole pipe and drives pix_stall
// reset clears every valid bit and loads the register defaults; no clearing pass
`timescale 1ns / 1ps

module snow_effect_hsl_pixel_top
    import sehsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [7:0]            red_in,
    input  logic [7:0]            green_in,
    input  logic [7:0]            blue_in,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [7:0]            red_out,
    output logic [7:0]            green_out,
    output logic [7:0]            blue_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int F = FRAC_BITS;
    localparam int NW = F + 11;
    localparam int LW = F + 1;
    localparam int OW = F + 5;

    sehsl_cfg_t cfg_reg;

    logic adv;

    logic          pre_valid;
    logic          pre_gray;
    logic [NW-1:0] pre_num [LANES];
    logic [DW-1:0] pre_den [LANES];

    logic          div_valid;
    logic          div_gray;
    logic [LW-1:0] div_quo [LANES];

    logic          lt_valid;
    logic          lt_gray;
    logic [OW-1:0] lt_l;
    logic [LW-1:0] lt_s;
    logic [LW-1:0] lt_h;

    // whole pipe moves unless the output holds a request that is stalled
    assign adv = !(res_valid && res_stall);
    assign pix_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain       <= GAIN_RESET;
            cfg_reg.snow_level <= SNOW_RESET;
            cfg_reg.dark_boost <= 1'b0;
            cfg_reg.gray       <= 1'b0;
            cfg_reg.sgn        <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_GAIN:       cfg_reg.gain       <= cfg_data;
                CFG_SNOW_LEVEL: cfg_reg.snow_level <= cfg_data;
                CFG_DARK_BOOST: cfg_reg.dark_boost <= cfg_data[0];
                CFG_GRAY_MODE:  cfg_reg.gray       <= cfg_data[0];
                CFG_SIGNED:     cfg_reg.sgn        <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    sehsl_pre #(.F(F)) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pix_valid),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cfg       (cfg_reg),
        .out_valid (pre_valid),
        .out_gray  (pre_gray),
        .num       (pre_num),
        .den       (pre_den)
    );

    sehsl_div #(.F(F)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pre_valid),
        .in_gray   (pre_gray),
        .num       (pre_num),
        .den       (pre_den),
        .out_valid (div_valid),
        .out_gray  (div_gray),
        .quo       (div_quo)
    );

    sehsl_light #(.F(F)) u_light (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_gray   (div_gray),
        .l_in      (div_quo[LANE_L]),
        .s_in      (div_quo[LANE_S]),
        .h_in      (div_quo[LANE_H]),
        .cfg       (cfg_reg),
        .out_valid (lt_valid),
        .out_gray  (lt_gray),
        .l_out     (lt_l),
        .s_out     (lt_s),
        .h_out     (lt_h)
    );

    sehsl_rgb #(.F(F)) u_rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (lt_valid),
        .in_gray   (lt_gray),
        .l_in      (lt_l),
        .s_in      (lt_s),
        .h_in      (lt_h),
        .sgn       (cfg_reg.sgn),
        .out_valid (res_valid),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

/* tb/snow_effect_hsl_pixel_top_test.sv */
// testbench for the snow effect pixel pipeline: predictor, driver and result checker
`timescale 1ns / 1ps

module snow_effect_hsl_pixel_top_test;
    import sehsl_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;
    localparam int LATENCY = FB + 14;

    // indexes past the last register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [7:0] red_out, green_out, blue_out;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [15:0] gain_q = GAIN_RESET;
    logic [15:0] snow_q = SNOW_RESET;
    logic boost_q = 1'b0, gray_q = 1'b0, sgn_q = 1'b0;

    pixel_t expected_pixels[$];
    int mismatches = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int rx_wait = 0;
    int rx_seen = 0;
    bit hold_results = 1'b0;

    snow_effect_hsl_pixel_top u_top (.*);

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint rdiv(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint fx_const(longint n, longint d);
        return (n * ONE + d / 2) / d;
    endfunction

    function automatic longint snow_lightness(longint l, bit may_exclude, longint h, longint s);
        bit band;
        if (boost_q && l >= 0 && l <= fx_const(100, 255))
            l = rdiv(500 * l * ONE - 765 * l * l, 200 * ONE);
        if (l * 65536 <= longint'(snow_q) * ONE)
        begin
            band = may_exclude && h >= fx_const(514, 1000) && h <= fx_const(630, 1000)
                   && s >= fx_const(196, 1000) && l >= fx_const(196, 1000);
            if (!band)
                l = rdiv(l * longint'(gain_q), 4096);
        end
        return l;
    endfunction

    function automatic logic [7:0] scale_to_byte(longint c);
        longint v;
        v = rdiv(c * 255, ONE);
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return sgn_q ? (v[7:0] ^ 8'h80) : v[7:0];
    endfunction

    function automatic longint hsl_channel(longint t, longint s, longint l);
        longint ct;
        if (t > ONE)
            t = ONE;
        ct = rdiv(2 * s * t, ONE) + ONE - s;
        if (2 * l >= ONE)
            return rdiv((ONE - l) * ct, ONE) + 2 * l - ONE;
        return rdiv(l * ct, ONE);
    endfunction

    function automatic pixel_t snow_pixel(pixel_t p);
        longint r, g, b, mx, mn, delta, sum, l, s, h, n, tr, tg, tb;
        pixel_t res;
        r = longint'(p.red ^ (sgn_q ? 8'h80 : 8'h00));
        g = longint'(p.green ^ (sgn_q ? 8'h80 : 8'h00));
        b = longint'(p.blue ^ (sgn_q ? 8'h80 : 8'h00));
        s = 0;
        h = 0;
        if (gray_q)
        begin
            l = snow_lightness(rdiv(r * ONE, 255), 1'b0, 0, 0);
            res.red = scale_to_byte(l);
            res.green = 8'd0;
            res.blue = 8'd0;
            return res;
        end
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
        sum = mx + mn;
        l = rdiv(sum * ONE, 510);
        if (delta != 0)
        begin
            s = rdiv(delta * ONE, (sum <= 255) ? sum : 510 - sum);
            if (mx == r)
                n = g - b;
            else if (mx == g)
                n = 2 * delta + b - r;
            else
                n = 4 * delta + r - g;
            if (n < 0)
                n += 6 * delta;
            h = rdiv(n * ONE, 6 * delta);
        end
        l = snow_lightness(l, 1'b1, h, s);
        if (3 * h < ONE)
        begin
            tr = 2 * ONE - 6 * h; tg = 6 * h; tb = 0;
        end
        else if (3 * h < 2 * ONE)
        begin
            tr = 0; tg = 4 * ONE - 6 * h; tb = 6 * h - 2 * ONE;
        end
        else
        begin
            tr = 6 * h - 4 * ONE; tg = 0; tb = 6 * (ONE - h);
        end
        res.red = scale_to_byte(hsl_channel(tr, s, l));
        res.green = scale_to_byte(hsl_channel(tg, s, l));
        res.blue = scale_to_byte(hsl_channel(tb, s, l));
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 pixels_checked);
        mismatches++;
    endtask

    // result side: a random stall after each checked result, long hold when asked
    always @(negedge clk)
    begin
        if (pixels_checked != rx_seen)
        begin
            rx_seen = pixels_checked;
            rx_wait = $urandom_range(0, 9);
        end
        if (hold_results)
            res_stall <= 1'b1;
        else if (rx_wait > 0)
        begin
            res_stall <= 1'b1;
            rx_wait--;
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("result with no request pending", red_out, 8'd0);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (red_out !== want.red)
                    report_mismatch("red", red_out, want.red);
                if (green_out !== want.green)
                    report_mismatch("green", green_out, want.green);
                if (blue_out !== want.blue)
                    report_mismatch("blue", blue_out, want.blue);
            end
            pixels_checked++;
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        expected_pixels.push_back(snow_pixel('{r, g, b}));
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        int guard;
        guard = 0;
        pix_valid <= 1'b0;
        while (expected_pixels.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_GAIN:       gain_q = value;
            CFG_SNOW_LEVEL: snow_q = value;
            CFG_DARK_BOOST: boost_q = value[0];
            CFG_GRAY_MODE:  gray_q = value[0];
            CFG_SIGNED:     sgn_q = value[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(logic [15:0] gain, logic [15:0] snow, bit boost, bit gray,
                            bit sgn);
        drain_pipe();
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_SNOW_LEVEL, snow);
        write_reg(CFG_DARK_BOOST, {15'h7ffe, boost});
        write_reg(CFG_GRAY_MODE, {15'h0, gray});
        write_reg(CFG_SIGNED, {15'h1234, sgn});
    endtask

    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd128);   // negative hue wraps
        send_pixel(8'd40, 8'd140, 8'd200);  // bluish band
        send_pixel(8'd60, 8'd170, 8'd190);
        send_pixel(8'd200, 8'd200, 8'd10);  // red and green tie
        send_pixel(8'd10, 8'd200, 8'd200);  // green and blue tie
        send_pixel(8'd30, 8'd20, 8'd90);
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endtask

    task automatic test_bluish_band(int count);
        // hue near cyan-blue with good saturation
        repeat (count)
            send_pixel(8'($urandom_range(0, 90)), 8'($urandom_range(100, 230)),
                       8'($urandom_range(150, 255)));
    endtask

    task automatic test_config_sweep();
        set_mode(16'h0000, 16'hffff, 1'b0, 1'b0, 1'b0);
        test_directed();
        test_random(80);
        set_mode(16'hffff, 16'hffff, 1'b1, 1'b0, 1'b0); // gain above one, clamps
        test_directed();
        test_random(80);
        set_mode(16'd6000, 16'd0, 1'b1, 1'b0, 1'b1);
        test_random(100);
        set_mode(16'd8192, 16'd40000, 1'b0, 1'b1, 1'b0);
        test_directed();
        test_random(100);
        set_mode(16'd2048, 16'd50000, 1'b1, 1'b1, 1'b1);
        test_random(100);
        set_mode(16'd10000, 16'd36000, 1'b1, 1'b0, 1'b0);
        test_bluish_band(150);
        drain_pipe();
        write_reg(CFG_SPARE_HI, 16'hffff);  // unused index ignored
        write_reg(CFG_SPARE_LO, 16'h0000);
        test_random(40);
    endtask

    task automatic test_backpressure();
        set_mode(16'd12000, 16'd45000, 1'b0, 1'b0, 1'b1);
        fork
            begin
                hold_results = 1'b1;
                repeat (LATENCY * 3) @(negedge clk);
                hold_results = 1'b0;
            end
            test_random(120);
        join
    endtask

    task automatic test_random_modes(int phases);
        repeat (phases)
        begin
            set_mode(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            test_random(60);
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(100);
        test_config_sweep();
        test_backpressure();
        test_random_modes(6);
        drain_pipe();
        $display("covered %0d pixels across rgb, gray, signed, dark boost and gain extremes",
                 pixels_sent);
        $display("checked %0d results, including a long output hold", pixels_checked);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* snow_effect_hsl_pixel_top.f */
design/sehsl_pkg.sv
design/sehsl_pre.sv
design/sehsl_div.sv
design/sehsl_light.sv
design/sehsl_rgb.sv
design/snow_effect_hsl_pixel_top.sv
tb/snow_effect_hsl_pixel_top_test.sv
